FILE: hw/rtl/linear_interp_resampler_8bit_assert.svh
// Assertion macros shared by the resampler RTL.
`ifndef LINEAR_INTERP_RESAMPLER_8BIT_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_8BIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lirs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LIRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lirs assertion failed");

`endif

FILE: hw/rtl/lirs_pkg.sv
package lirs_pkg;

    // Widths of the audio samples and of the rate step register.
    localparam int SAMPLE_W = 8;
    localparam int STEP_W   = 21;

    // Outputs made for one input sample are capped at this count.
    localparam int MAX_OUTS = 64;
    localparam int CNT_W    = $clog2(MAX_OUTS + 1);

    // The step register comes out of reset at unity rate.
    localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [STEP_W-1:0]   t_step;
    typedef logic [CNT_W-1:0]    t_count;

endpackage

FILE: hw/rtl/lirs_interp.sv
module lirs_interp #(
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  lirs_pkg::t_sample          i_prev,
    input  lirs_pkg::t_sample          i_cur,
    input  logic [PHASE_FRAC_BITS-1:0] i_phase,
    output lirs_pkg::t_sample          o_sample
);
    import lirs_pkg::*;

    localparam int PROD_W = SAMPLE_W + 1 + PHASE_FRAC_BITS + 1;

    logic signed [SAMPLE_W:0]        diff;
    logic signed [PHASE_FRAC_BITS:0] phase_s;
    logic signed [PROD_W-1:0]        r_prod;
    logic signed [PROD_W-1:0]        shifted;

    // Signed difference between the two samples and the phase as a positive operand.
    assign diff    = $signed({1'b0, i_cur}) - $signed({1'b0, i_prev});
    assign phase_s = $signed({1'b0, i_phase});

    // The one multiplier of the block, registered before the offset add.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= PROD_W'(diff) * PROD_W'(phase_s);
        end
    end

    // Arithmetic shift floors the scaled difference; the result stays between the samples.
    assign shifted  = r_prod >>> PHASE_FRAC_BITS;
    assign o_sample = i_prev + shifted[SAMPLE_W-1:0];

endmodule

FILE: hw/rtl/linear_interp_resampler_8bit.sv
// Linear interpolation resampler for unsigned 8-bit mono audio. An input sample
// that only primes the state is taken in the idle state alone. Otherwise the
// input transfer is followed, for each output it produces, by a phase check that
// starts the multiply and then the output load, and a last check closes the
// interval; the cap is 64 outputs per input sample. A final sample that yields
// no output also passes through FLAG for its flagged copy, and an output load or
// flagged copy waits whenever the output side holds back a transfer. This order
// is set by the check and load loop around the single shared multiplier. The
// step register holds input rate over output rate with PHASE_FRAC_BITS fraction
// bits and may be written only while the block is idle.
module linear_interp_resampler_8bit #(
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  lirs_pkg::t_step   i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  lirs_pkg::t_sample i_sample_in,
    input  logic              i_last_in,
    output logic              o_valid,
    input  logic              i_ready,
    output lirs_pkg::t_sample o_sample_out,
    output logic              o_end_of_run
);
    import lirs_pkg::*;

`include "linear_interp_resampler_8bit_assert.svh"

    localparam int PW = ((PHASE_FRAC_BITS + 1 > STEP_W) ? PHASE_FRAC_BITS + 1 : STEP_W) + 1;
    localparam logic [PW-1:0] PhaseOne  = PW'(1) << PHASE_FRAC_BITS;
    localparam logic [PW-1:0] StepLimit = PW'(1) << STEP_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;
    localparam logic [1:0] S_FLAG  = 2'd3;

    logic [1:0]    r_state, n_state;
    t_step         r_step;
    t_sample       r_prev, n_prev;
    logic [PW-1:0] r_phase, n_phase;
    logic          r_have, n_have;
    t_sample       r_cur, n_cur;
    logic          r_last, n_last;
    t_count        r_cnt, n_cnt;
    logic          r_final, n_final;
    logic          r_out_valid, n_out_valid;
    t_sample       r_out_sample, n_out_sample;
    logic          r_out_end, n_out_end;

    logic          in_xfer;
    logic          out_free;
    logic          ph_lt_one;
    logic          cap_hit;
    logic [PW-1:0] ph_next;
    logic          mul_load;
    t_sample       interp_sample;

    // Shared interpolation unit.
    lirs_interp #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_interp (
        .i_clk    (i_clk),
        .i_load   (mul_load),
        .i_prev   (r_prev),
        .i_cur    (r_cur),
        .i_phase  (r_phase[PHASE_FRAC_BITS-1:0]),
        .o_sample (interp_sample)
    );

    assign o_ready      = (r_state == S_IDLE);
    assign in_xfer      = i_valid && o_ready;
    assign out_free     = !r_out_valid || i_ready;
    assign ph_lt_one    = (r_phase < PhaseOne);
    assign cap_hit      = (r_cnt == CNT_W'(MAX_OUTS));
    assign ph_next      = r_phase + PW'(r_step);
    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_end_of_run = r_out_end;

    // Sequencer: one output per pass through check and emit.
    always_comb begin
        n_state      = r_state;
        n_prev       = r_prev;
        n_phase      = r_phase;
        n_have       = r_have;
        n_cur        = r_cur;
        n_last       = r_last;
        n_cnt        = r_cnt;
        n_final      = r_final;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_sample = r_out_sample;
        n_out_end    = r_out_end;
        mul_load     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cur  = i_sample_in;
                    n_last = i_last_in;
                    n_cnt  = '0;
                    if (!r_have) begin
                        // The first sample of a sound only primes the state.
                        n_prev  = i_sample_in;
                        n_phase = '0;
                        n_have  = 1'b1;
                        n_state = i_last_in ? S_FLAG : S_IDLE;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (ph_lt_one && !cap_hit) begin
                    // Start a product and note whether this output ends the interval.
                    mul_load = 1'b1;
                    n_final  = (ph_next >= PhaseOne) || (r_cnt == CNT_W'(MAX_OUTS - 1));
                    n_state  = S_EMIT;
                end else if (r_last) begin
                    if (r_cnt == '0) begin
                        n_state = S_FLAG;
                    end else begin
                        n_prev  = '0;
                        n_phase = '0;
                        n_have  = 1'b0;
                        n_state = S_IDLE;
                    end
                end else begin
                    // Close interval: phase less one input period, or zero if under one.
                    n_phase = ph_lt_one ? '0 : (r_phase - PhaseOne);
                    n_prev  = r_cur;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = interp_sample;
                    n_out_end    = r_last && r_final;
                    n_phase      = ph_next;
                    n_cnt        = r_cnt + CNT_W'(1);
                    n_state      = S_CHECK;
                end
            end
            S_FLAG: begin
                // An end of sound with no output in its interval emits the sample itself.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_cur;
                    n_out_end    = 1'b1;
                    n_prev       = '0;
                    n_phase      = '0;
                    n_have       = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_phase     <= '0;
            r_have      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_phase     <= n_phase;
            r_have      <= n_have;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Step register, written directly by the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (i_cfg_wr_en) begin
            r_step <= i_cfg_wr_data;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_last       <= n_last;
        r_final      <= n_final;
        r_out_sample <= n_out_sample;
        r_out_end    <= n_out_end;
    end

    `LIRS_ASSERT_SAME(a_cnt_capped, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(MAX_OUTS))
    `LIRS_ASSERT_SAME(a_cleared_phase, i_clk, i_rst_n, !r_have, r_phase == '0)
    `LIRS_ASSERT_SAME(a_idle_phase_fits, i_clk, i_rst_n, r_state == S_IDLE, r_phase < StepLimit)
    `LIRS_ASSERT_NEXT(a_emit_loads_output, i_clk, i_rst_n, r_state == S_EMIT && out_free, r_out_valid && r_state == S_CHECK)

endmodule

FILE: bench/linear_interp_resampler_8bit_test.sv
module linear_interp_resampler_8bit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lirs_pkg::*;

    localparam int          FRAC_BITS       = 16;
    localparam logic [31:0] UNITY           = 32'd1 << FRAC_BITS;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          QUIET_LIMIT     = 4000;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          PHASES          = 8;
    localparam int          ITEMS_PER_PHASE = 55;
    localparam int          PRESSURE_PHASE  = 5;
    localparam int          PAUSE_PHASE     = 7;

    // Idle percentages per random phase: none, sender, receiver and both.
    localparam int TX_IDLE  [PHASES] = '{0, 46, 0, 38, 46, 0, 38, 0};
    localparam int RX_STALL [PHASES] = '{0, 0, 46, 38, 0, 46, 38, 0};
    localparam int FIXED_STEP [PHASES] =
        '{65536, 0, 1024, 0, 1048576, 0, 0, 71332};

    typedef struct packed {
        t_sample sample;
        logic    eor;
    } t_audio_out;

    typedef enum logic [1:0] {ROW_STEP, ROW_SILENT, ROW_ONE, ROW_PREDICT} t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_step     value;
        logic      is_last;
        t_sample   exp_sample;
        logic      exp_eor;
    } t_stim_row;

    localparam int N_DIRECTED = 28;

    // Directed rows: a step write or a sample; typed results where obvious.
    t_stim_row directed [N_DIRECTED] = '{
        // Unity rate out of reset: each sample emits the one before it.
        '{ROW_SILENT,  21'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ONE,     21'hFF, 1'b0, 8'h00, 1'b0},
        '{ROW_ONE,     21'h00, 1'b0, 8'hFF, 1'b0},
        '{ROW_ONE,     21'h80, 1'b0, 8'h00, 1'b0},
        '{ROW_ONE,     21'h80, 1'b1, 8'h80, 1'b1},
        // A lone final sample comes straight back, flagged.
        '{ROW_ONE,     21'h5A, 1'b1, 8'h5A, 1'b1},
        '{ROW_SILENT,  21'hA5, 1'b0, 8'h00, 1'b0},
        '{ROW_ONE,     21'h3C, 1'b1, 8'hA5, 1'b1},
        // Two times upsampling.
        '{ROW_STEP,    21'd32768, 1'b0, 8'h00, 1'b0},
        '{ROW_SILENT,  21'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_PREDICT, 21'hFF, 1'b0, 8'h00, 1'b0},
        '{ROW_PREDICT, 21'h10, 1'b1, 8'h00, 1'b0},
        // Largest stated step: one output, then whole intervals with none.
        '{ROW_STEP,    21'd1048576, 1'b0, 8'h00, 1'b0},
        '{ROW_SILENT,  21'h20, 1'b0, 8'h00, 1'b0},
        '{ROW_ONE,     21'h40, 1'b0, 8'h20, 1'b0},
        '{ROW_SILENT,  21'h60, 1'b0, 8'h00, 1'b0},
        '{ROW_ONE,     21'h70, 1'b1, 8'h70, 1'b1},
        // Smallest stated step: 64 outputs per interval.
        '{ROW_STEP,    21'd1024, 1'b0, 8'h00, 1'b0},
        '{ROW_SILENT,  21'hFF, 1'b0, 8'h00, 1'b0},
        '{ROW_PREDICT, 21'h00, 1'b1, 8'h00, 1'b0},
        // Zero step: the output cap ends the loop and the phase is cleared.
        '{ROW_STEP,    21'd0, 1'b0, 8'h00, 1'b0},
        '{ROW_SILENT,  21'h01, 1'b0, 8'h00, 1'b0},
        '{ROW_PREDICT, 21'hFE, 1'b0, 8'h00, 1'b0},
        '{ROW_PREDICT, 21'h02, 1'b1, 8'h00, 1'b0},
        // All ones in the step register.
        '{ROW_STEP,    21'h1FFFFF, 1'b0, 8'h00, 1'b0},
        '{ROW_SILENT,  21'h33, 1'b0, 8'h00, 1'b0},
        '{ROW_ONE,     21'hCC, 1'b0, 8'h33, 1'b0},
        '{ROW_ONE,     21'h99, 1'b1, 8'h99, 1'b1}
    };

    logic    i_clk         = 1'b0;
    logic    i_rst_n       = 1'b0;
    logic    i_cfg_wr_en   = 1'b0;
    t_step   i_cfg_wr_data = '0;
    logic    i_valid       = 1'b0;
    logic    o_ready;
    t_sample i_sample_in   = '0;
    logic    i_last_in     = 1'b0;
    logic    o_valid;
    logic    i_ready       = 1'b0;
    t_sample o_sample_out;
    logic    o_end_of_run;

    // Resampler state as predicted from the accepted samples.
    t_step       rate_step    = STEP_RESET;
    t_sample     held_sample  = '0;
    logic [31:0] held_phase   = '0;
    logic        holding      = 1'b0;
    t_audio_out  step_outs[$];
    t_audio_out  expected_outs[$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_req  = 0;
    int quiet_cycles = 0;
    int n_samples    = 0;
    int n_outputs    = 0;
    int n_flags      = 0;
    int n_settings   = 0;
    int n_errors     = 0;

    linear_interp_resampler_8bit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample_in   (i_sample_in),
        .i_last_in     (i_last_in),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_sample_out  (o_sample_out),
        .o_end_of_run  (o_end_of_run)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Point between a and b at the given phase, rounded toward minus infinity.
    function automatic t_sample blend(t_sample a, t_sample b, logic [31:0] ph);
        longint diff;
        longint prod;
        diff = longint'(b) - longint'(a);
        prod = diff * longint'(ph);
        return t_sample'(longint'(a) + (prod >>> FRAC_BITS));
    endfunction

    // Works out the outputs that one accepted sample causes, into step_outs.
    function automatic void resample_input(t_sample cur, logic is_last);
        int          n;
        logic [31:0] ph;
        n = 0;
        step_outs.delete();
        if (!holding) begin
            held_sample = cur;
            held_phase  = '0;
            holding     = 1'b1;
        end else begin
            ph = held_phase;
            while (ph < UNITY && n < MAX_OUTS) begin
                step_outs.push_back(t_audio_out'{blend(held_sample, cur, ph), 1'b0});
                n++;
                ph += rate_step;
            end
            held_phase  = (ph >= UNITY) ? ph - UNITY : '0;
            held_sample = cur;
        end
        if (is_last) begin
            if (n > 0)
                step_outs[n-1].eor = 1'b1;
            else
                step_outs.push_back(t_audio_out'{cur, 1'b1});
            held_sample = '0;
            held_phase  = '0;
            holding     = 1'b0;
        end
    endfunction

    // Offers one sample, waits for its transfer, then predicts its outputs.
    task automatic offer_sample(input t_sample s, input logic is_last, input logic use_model);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_in <= s;
        i_last_in   <= is_last;
        do @(posedge i_clk); while (!o_ready);
        n_samples++;
        resample_input(s, is_last);
        if (use_model) begin
            foreach (step_outs[k])
                expected_outs.push_back(step_outs[k]);
        end
    endtask

    // Stops offering and waits until the block has delivered everything.
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_outs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_step(input t_step v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        rate_step = v;
        n_settings++;
    endtask

    // Mostly uniform samples, with the rails picked more often.
    function automatic t_sample pick_sample();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return t_sample'($urandom_range(255));
        endcase
    endfunction

    // Output side: random stalls, plus a long hold-off when one is requested.
    initial begin : drive_ready
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Compare every output transfer with the oldest predicted output.
    always @(posedge i_clk) begin : check_outputs
        t_audio_out want;
        if (i_rst_n && o_valid && i_ready) begin
            n_outputs++;
            if (o_end_of_run)
                n_flags++;
            if (expected_outs.size() == 0) begin
                $display("%0t: unexpected output, sample %h end_of_run %b",
                         $time, o_sample_out, o_end_of_run);
                n_errors++;
            end else begin
                want = expected_outs.pop_front();
                if (o_sample_out !== want.sample) begin
                    $display("%0t: sample_out expected %h actual %h",
                             $time, want.sample, o_sample_out);
                    n_errors++;
                end
                if (o_end_of_run !== want.eor) begin
                    $display("%0t: end_of_run expected %b actual %b",
                             $time, want.eor, o_end_of_run);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : run_stimulus
        t_step step;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        foreach (directed[r]) begin
            case (directed[r].kind)
                ROW_STEP: begin
                    settle();
                    write_step(directed[r].value);
                end
                ROW_PREDICT: begin
                    offer_sample(t_sample'(directed[r].value), directed[r].is_last, 1'b1);
                end
                default: begin
                    offer_sample(t_sample'(directed[r].value), directed[r].is_last, 1'b0);
                    if (directed[r].kind == ROW_ONE)
                        expected_outs.push_back(
                            t_audio_out'{directed[r].exp_sample, directed[r].exp_eor});
                end
            endcase
        end

        // Random phases, each at its own step and idling pattern.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1, 3, 6: step = t_step'($urandom_range(1048576, 1024));
                PRESSURE_PHASE: step = t_step'($urandom_range(70000, 16384));
                default: step = t_step'(FIXED_STEP[p]);
            endcase
            settle();
            write_step(step);
            tx_idle_pct  = TX_IDLE[p];
            rx_stall_pct = RX_STALL[p];
            // Output side holds off while samples keep coming, so the block backs up.
            if (p == PRESSURE_PHASE)
                rx_hold_req = HOLD_CYCLES;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Halfway through, stop sending until the block has drained.
                if (p == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2)
                    settle();
                offer_sample(pick_sample(), $urandom_range(19) == 0, 1'b1);
            end
        end

        settle();
        $display("Sent %0d samples over %0d step settings; checked %0d outputs, %0d flagged.",
                 n_samples, n_settings, n_outputs, n_flags);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
